>>> rtl/hkc_pkg.sv
`default_nettype none
package hkc_pkg;

	localparam int CURVE_COUNT_DEF = 16;
	localparam int FRAC_BITS = 12;
	localparam int TBITS = 16;

	localparam logic ACT_EVAL = 1'b0;
	localparam logic ACT_WRITE = 1'b1;
	localparam logic [1:0] SEL_FLAGS = 2'd3;

	typedef enum logic [1:0] {
		MODE_DIRECT = 2'b00,
		MODE_LINEAR = 2'b01,
		MODE_HERMITE = 2'b10
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic oor;
		logic signed [15:0] lk;
		logic signed [15:0] val;
		logic signed [15:0] ya;
		logic signed [15:0] yb;
		logic signed [15:0] wa;
		logic signed [15:0] zb;
		logic [15:0] d;
		logic signed [16:0] dx;
		logic [15:0] rem;
		logic [15:0] quo;
		logic [15:0] t2;
		logic [15:0] t3;
		logic signed [18:0] h00;
		logic signed [18:0] h01;
		logic signed [18:0] h10;
		logic signed [18:0] h11;
		logic signed [34:0] p00;
		logic signed [34:0] p01;
		logic signed [31:0] hd10;
		logic signed [31:0] hd11;
		logic signed [47:0] q10;
		logic signed [47:0] q11;
		logic signed [35:0] psum;
		logic signed [32:0] lin;
	} item_t;

	// floor((v + 2^(sh-1)) / 2^sh), then clip to 16 bits signed
	function automatic logic signed [15:0] rnd_sat(input logic signed [55:0] v,
		input int unsigned sh);
		logic signed [55:0] b;
		logic signed [55:0] r;
		b = v + (56'sd1 <<< (sh - 1));
		r = b >>> sh;
		if (r > 56'sd32767) begin
			rnd_sat = 16'sh7fff;
		end else if (r < -56'sd32768) begin
			rnd_sat = 16'sh8000;
		end else begin
			rnd_sat = r[15:0];
		end
	endfunction

endpackage
`default_nettype wire

>>> rtl/hkc_ram.sv
`default_nettype none
module hkc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/three_key_hermite_curve_eval.sv
`default_nettype none
// channel  | beat signals              | payload
// item     | item_valid / item_stall   | action, curve_index, key_select, key_word, lookup
// curve    | curve_valid / curve_stall | curve_value
//
// one item per cycle unless item_stall is high; an evaluate beat shows its curve_value after passing every stage
// the pipeline holds the 16-stage restoring divider plus the hermite multiply stages
// a write beat with an in-range curve_index updates the table at acceptance; no write beat gives a curve beat
// reset clears only the stage valid bits; table words read as garbage until written
// each stage moves when the next one is empty or moving, so bubbles close up under stall
module three_key_hermite_curve_eval #(
	parameter int CURVE_COUNT = hkc_pkg::CURVE_COUNT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire logic action,
	input wire logic [3:0] curve_index,
	input wire logic [1:0] key_select,
	input wire logic [63:0] key_word,
	input wire logic signed [15:0] lookup,
	output logic curve_valid,
	input wire logic curve_stall,
	output logic signed [15:0] curve_value
);

	localparam int AW = (CURVE_COUNT > 1) ? $clog2(CURVE_COUNT) : 1;
	localparam int NS = 26;
	localparam int DIV_FIRST = 5;
	localparam int DIV_LAST = DIV_FIRST + hkc_pkg::TBITS - 1;
	localparam int F = hkc_pkg::FRAC_BITS;

	hkc_pkg::item_t pl_s [1:NS];
	hkc_pkg::item_t nxt [1:NS];
	logic [NS:1] vld_s;
	logic [NS:1] en;

	logic [8:0] idx_w;
	logic [AW-1:0] addr;
	logic oor_in;
	logic accept;
	logic eval_acc;
	logic wr;
	logic [63:0] kw [3];
	logic [1:0] flg;

	assign idx_w = 9'(curve_index);
	assign addr = idx_w[AW-1:0];
	assign oor_in = idx_w >= 9'(CURVE_COUNT);

	always_comb begin
		en[NS] = !vld_s[NS] || !curve_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign item_stall = !en[1];
	assign accept = item_valid && en[1];
	assign eval_acc = accept && (action == hkc_pkg::ACT_EVAL);
	assign wr = accept && (action == hkc_pkg::ACT_WRITE) && !oor_in;

	for (genvar g = 0; g < 3; g++) begin : g_key
		hkc_ram #(.WIDTH(64), .DEPTH(CURVE_COUNT)) u_key (
			.clk(clk),
			.we(wr && (key_select == 2'(g))),
			.waddr(addr),
			.wdata(key_word),
			.re(eval_acc),
			.raddr(addr),
			.rdata(kw[g])
		);
	end

	hkc_ram #(.WIDTH(2), .DEPTH(CURVE_COUNT)) u_flags (
		.clk(clk),
		.we(wr && (key_select == hkc_pkg::SEL_FLAGS)),
		.waddr(addr),
		.wdata(key_word[1:0]),
		.re(eval_acc),
		.raddr(addr),
		.rdata(flg)
	);

	always_comb begin
		logic signed [15:0] xs [3];
		logic signed [15:0] ys [3];
		logic signed [15:0] zs [3];
		logic signed [15:0] ws [3];
		logic signed [15:0] lk;
		logic signed [15:0] xa;
		logic signed [15:0] xb;
		logic signed [16:0] diff;
		logic signed [16:0] num;
		logic seg1;
		logic [16:0] r2;
		logic [31:0] sq;
		logic signed [18:0] t2e;
		logic signed [18:0] t3e;
		logic signed [18:0] te;
		logic signed [35:0] hd;
		logic signed [55:0] s;

		for (int j = 0; j < 3; j++) begin
			xs[j] = kw[j][15:0];
			ys[j] = kw[j][31:16];
			zs[j] = kw[j][47:32];
			ws[j] = kw[j][63:48];
		end
		seg1 = 1'b0;

		nxt[1] = pl_s[1];
		nxt[1].lk = lookup;
		nxt[1].oor = oor_in;
		for (int k = 2; k <= NS; k++) begin
			nxt[k] = pl_s[k-1];
		end

		// decode: zero for an out-of-range index, else pick exact hit, clamp, linear tail or segment
		lk = pl_s[1].lk;
		nxt[2].mode = hkc_pkg::MODE_DIRECT;
		nxt[2].val = '0;
		priority if (pl_s[1].oor) begin
			nxt[2].val = '0;
		end else if (lk == xs[0]) begin
			nxt[2].val = ys[0];
		end else if (lk == xs[1]) begin
			nxt[2].val = ys[1];
		end else if (lk == xs[2]) begin
			nxt[2].val = ys[2];
		end else if (lk < xs[0]) begin
			nxt[2].val = ys[0];
			nxt[2].ya = ys[0];
			nxt[2].zb = zs[0];
			nxt[2].dx = 17'(lk) - 17'(xs[0]);
			if (!flg[0]) begin
				nxt[2].mode = hkc_pkg::MODE_LINEAR;
			end
		end else if (lk < xs[2] && lk < xs[1]) begin
			seg1 = 1'b0;
			nxt[2].mode = hkc_pkg::MODE_HERMITE;
		end else if (lk < xs[2]) begin
			seg1 = 1'b1;
			nxt[2].mode = hkc_pkg::MODE_HERMITE;
		end else if (lk < xs[1]) begin
			seg1 = 1'b0;
			nxt[2].mode = hkc_pkg::MODE_HERMITE;
		end else begin
			nxt[2].val = ys[2];
			nxt[2].ya = ys[2];
			nxt[2].zb = zs[2];
			nxt[2].dx = 17'(lk) - 17'(xs[2]);
			if (!flg[1]) begin
				nxt[2].mode = hkc_pkg::MODE_LINEAR;
			end
		end
		xa = seg1 ? xs[1] : xs[0];
		xb = seg1 ? xs[2] : xs[1];
		diff = 17'(xb) - 17'(xa);
		num = 17'(lk) - 17'(xa);
		if (nxt[2].mode == hkc_pkg::MODE_HERMITE) begin
			nxt[2].ya = seg1 ? ys[1] : ys[0];
			nxt[2].wa = seg1 ? ws[1] : ws[0];
			nxt[2].yb = seg1 ? ys[2] : ys[1];
			nxt[2].zb = seg1 ? zs[2] : zs[1];
			nxt[2].d = diff[15:0];
			nxt[2].rem = num[15:0];
			nxt[2].quo = '0;
		end

		// linear tail: y*2^F + dx*z, then round and saturate
		nxt[3].lin = pl_s[2].dx * pl_s[2].zb;
		if (pl_s[3].mode == hkc_pkg::MODE_LINEAR) begin
			nxt[4].val = hkc_pkg::rnd_sat((56'(pl_s[3].ya) <<< F) + 56'(pl_s[3].lin), F);
			nxt[4].mode = hkc_pkg::MODE_DIRECT;
		end

		// t = num * 2^16 / d, one quotient bit per stage
		for (int k = DIV_FIRST; k <= DIV_LAST; k++) begin
			r2 = {pl_s[k-1].rem, 1'b0};
			if (r2 >= {1'b0, pl_s[k-1].d}) begin
				nxt[k].rem = 16'(r2 - {1'b0, pl_s[k-1].d});
				nxt[k].quo = {pl_s[k-1].quo[14:0], 1'b1};
			end else begin
				nxt[k].rem = r2[15:0];
				nxt[k].quo = {pl_s[k-1].quo[14:0], 1'b0};
			end
		end

		sq = pl_s[DIV_LAST].quo * pl_s[DIV_LAST].quo;
		nxt[21].t2 = sq[31:16];
		sq = pl_s[21].t2 * pl_s[21].quo;
		nxt[22].t3 = sq[31:16];

		t2e = $signed({3'b000, pl_s[22].t2});
		t3e = $signed({3'b000, pl_s[22].t3});
		te = $signed({3'b000, pl_s[22].quo});
		nxt[23].h00 = 19'sd2 * t3e - 19'sd3 * t2e + 19'sd65536;
		nxt[23].h01 = 19'sd3 * t2e - 19'sd2 * t3e;
		nxt[23].h10 = t3e - 19'sd2 * t2e + te;
		nxt[23].h11 = t3e - t2e;

		// h10 and h11 stay below 2^15 in magnitude, so h*d fits 32 bits
		nxt[24].p00 = pl_s[23].h00 * pl_s[23].ya;
		nxt[24].p01 = pl_s[23].h01 * pl_s[23].yb;
		hd = pl_s[23].h10 * $signed({1'b0, pl_s[23].d});
		nxt[24].hd10 = hd[31:0];
		hd = pl_s[23].h11 * $signed({1'b0, pl_s[23].d});
		nxt[24].hd11 = hd[31:0];

		nxt[25].q10 = pl_s[24].hd10 * pl_s[24].wa;
		nxt[25].q11 = pl_s[24].hd11 * pl_s[24].zb;
		nxt[25].psum = 36'(pl_s[24].p00) + 36'(pl_s[24].p01);

		s = (56'(pl_s[25].psum) <<< F) + 56'(pl_s[25].q10) + 56'(pl_s[25].q11);
		if (pl_s[25].mode == hkc_pkg::MODE_HERMITE) begin
			nxt[26].val = hkc_pkg::rnd_sat(s, hkc_pkg::TBITS + F);
			nxt[26].mode = hkc_pkg::MODE_DIRECT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= eval_acc;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= NS; k++) begin
			if (en[k]) begin
				pl_s[k] <= nxt[k];
			end
		end
	end

	assign curve_valid = vld_s[NS];
	assign curve_value = pl_s[NS].val;

endmodule
`default_nettype wire

>>> rtl/hkc_chk.sv
`default_nettype none
module hkc_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire logic item_stall,
	input wire logic action,
	input wire logic [3:0] curve_index,
	input wire logic [1:0] key_select,
	input wire logic [63:0] key_word,
	input wire logic signed [15:0] lookup,
	input wire logic curve_valid,
	input wire logic curve_stall,
	input wire logic signed [15:0] curve_value
);

	// a held curve beat stays up
	a_curve_hold: assert property (@(posedge clk) disable iff (!arst_n)
		curve_valid && curve_stall |=> curve_valid)
		else $error("curve beat dropped while stalled");

	a_curve_stable: assert property (@(posedge clk) disable iff (!arst_n)
		curve_valid && curve_stall |=> $stable(curve_value))
		else $error("curve value changed while stalled");

	// input only backs up when every stage is full behind a stalled output
	a_item_stall: assert property (@(posedge clk)
		item_stall |-> curve_valid && curve_stall)
		else $error("item stalled with room in the pipeline");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !curve_valid)
		else $error("curve beat during reset");

endmodule

bind three_key_hermite_curve_eval hkc_chk u_hkc_chk (.*);
`default_nettype wire

>>> sim/tb_three_key_hermite_curve_eval.sv
`default_nettype none
module tb_three_key_hermite_curve_eval;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LATENCY = 26;
	localparam int CURVES = 16;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic action;
	logic [3:0] curve_index;
	logic [1:0] key_select;
	logic [63:0] key_word;
	logic signed [15:0] lookup;
	logic curve_valid;
	logic curve_stall;
	logic signed [15:0] curve_value;

	three_key_hermite_curve_eval dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.action(action), .curve_index(curve_index), .key_select(key_select),
		.key_word(key_word), .lookup(lookup),
		.curve_valid(curve_valid), .curve_stall(curve_stall), .curve_value(curve_value)
	);

	// shadow of the curve table
	logic [63:0] key_mirror [3*CURVES];
	logic [1:0] clamp_mirror [CURVES];

	logic signed [15:0] pending_values [$];
	int errors;
	int cycles;
	bit idle_on;
	bit hold_sink;
	int hold_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint half_of(logic [63:0] w, int pos);
		logic signed [15:0] h;
		h = w[pos +: 16];
		return longint'(h);
	endfunction

	function automatic longint round_half_up(longint v, int s);
		longint b;
		b = v + (longint'(1) << (s - 1));
		return b >>> s;
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic longint segment_value(logic [63:0] ka, logic [63:0] kb, longint lk);
		longint xa, ya, wa, yb, zb, d, num, t, t2, t3, h00, h01, h10, h11, s;
		xa = half_of(ka, 0);
		ya = half_of(ka, 16);
		wa = half_of(ka, 48);
		yb = half_of(kb, 16);
		zb = half_of(kb, 32);
		d = half_of(kb, 0) - xa;
		if (d <= 0)
			return yb;
		num = lk - xa;
		if (num < 0)
			num = 0;
		t = (num <<< hkc_pkg::TBITS) / d;
		t2 = (t * t) >>> hkc_pkg::TBITS;
		t3 = (t2 * t) >>> hkc_pkg::TBITS;
		h00 = 2 * t3 - 3 * t2 + (longint'(1) << hkc_pkg::TBITS);
		h01 = 3 * t2 - 2 * t3;
		h10 = t3 - 2 * t2 + t;
		h11 = t3 - t2;
		s = (h00 * ya + h01 * yb) * (longint'(1) << hkc_pkg::FRAC_BITS)
			+ (h10 * wa + h11 * zb) * d;
		return round_half_up(s, hkc_pkg::TBITS + hkc_pkg::FRAC_BITS);
	endfunction

	function automatic logic signed [15:0] curve_at(int c, longint lk);
		logic [63:0] k0, k1, k2;
		longint x0, x1, x2, one;
		logic [1:0] fl;
		k0 = key_mirror[c*3];
		k1 = key_mirror[c*3+1];
		k2 = key_mirror[c*3+2];
		x0 = half_of(k0, 0);
		x1 = half_of(k1, 0);
		x2 = half_of(k2, 0);
		fl = clamp_mirror[c];
		one = longint'(1) << hkc_pkg::FRAC_BITS;
		if (lk == x0)
			return clip16(half_of(k0, 16));
		if (lk == x1)
			return clip16(half_of(k1, 16));
		if (lk == x2)
			return clip16(half_of(k2, 16));
		if (lk < x0) begin
			if (fl[0])
				return clip16(half_of(k0, 16));
			return clip16(round_half_up(half_of(k0, 16) * one - (x0 - lk) * half_of(k0, 32),
				hkc_pkg::FRAC_BITS));
		end
		if (lk < x1)
			return clip16(segment_value(k0, k1, lk));
		if (lk < x2)
			return clip16(segment_value(k1, k2, lk));
		if (fl[1])
			return clip16(half_of(k2, 16));
		return clip16(round_half_up(half_of(k2, 16) * one + (lk - x2) * half_of(k2, 32),
			hkc_pkg::FRAC_BITS));
	endfunction

	// offer one beat, wait for acceptance, update the shadow and expectations
	task automatic send_beat(logic act, logic [3:0] c, logic [1:0] sel, logic [63:0] w,
		logic signed [15:0] lk);
		while (idle_on && $urandom_range(99) < 28) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		curve_index <= c;
		key_select <= sel;
		key_word <= w;
		lookup <= lk;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (act == hkc_pkg::ACT_WRITE) begin
			if (sel == hkc_pkg::SEL_FLAGS) begin
				clamp_mirror[c] = w[1:0];
			end else begin
				key_mirror[c*3+sel] = w;
			end
		end else begin
			pending_values.push_back(curve_at(int'(c), longint'(lk)));
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_values.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_curve(int c, logic signed [15:0] x0, logic signed [15:0] x1,
		logic signed [15:0] x2, logic [1:0] fl);
		logic signed [15:0] xs [3];
		xs[0] = x0;
		xs[1] = x1;
		xs[2] = x2;
		for (int k = 0; k < 3; k++)
			send_beat(hkc_pkg::ACT_WRITE, 4'(c), 2'(k),
				{$urandom(), $urandom()} & 64'hffffffffffff0000 | {48'd0, xs[k]},
				16'($urandom()));
		send_beat(hkc_pkg::ACT_WRITE, 4'(c), hkc_pkg::SEL_FLAGS,
			{$urandom(), 30'($urandom()), fl}, 16'($urandom()));
	endtask

	function automatic logic signed [15:0] key_x(int c, int k);
		return key_mirror[c*3+k][15:0];
	endfunction

	task automatic test_directed();
		write_curve(0, -16'sd4096, 16'sd0, 16'sd4096, 2'b00);
		write_curve(1, -16'sd4096, 16'sd0, 16'sd4096, 2'b11);
		// extreme y and tangents to reach saturation
		send_beat(hkc_pkg::ACT_WRITE, 4'd2, 2'd0,
			{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000}, 16'sd0);
		send_beat(hkc_pkg::ACT_WRITE, 4'd2, 2'd1,
			{16'h8000, 16'h8000, 16'h8000, 16'h0000}, 16'sd0);
		send_beat(hkc_pkg::ACT_WRITE, 4'd2, 2'd2,
			{16'h7fff, 16'h8000, 16'h7fff, 16'h7fff}, 16'sd0);
		send_beat(hkc_pkg::ACT_WRITE, 4'd2, hkc_pkg::SEL_FLAGS,
			64'hffffffffffffffff & ~64'd3, 16'sd0);
		// keys sharing an x
		write_curve(3, 16'sd100, 16'sd100, 16'sd100, 2'b10);
		for (int c = 0; c < 4; c++) begin
			send_beat(hkc_pkg::ACT_EVAL, 4'(c), 2'd0, 64'd0, 16'sh8000);
			send_beat(hkc_pkg::ACT_EVAL, 4'(c), 2'd0, 64'd0, 16'sh7fff);
			send_beat(hkc_pkg::ACT_EVAL, 4'(c), 2'd0, 64'd0, key_x(c, 1));
			send_beat(hkc_pkg::ACT_EVAL, 4'(c), 2'd0, 64'd0, key_x(c, 0) + 16'sd1);
		end
		drain();
	endtask

	task automatic random_curve(int c);
		logic signed [15:0] a, b, e;
		a = 16'($urandom());
		b = 16'($urandom());
		e = 16'($urandom());
		if ($urandom_range(3) != 0) begin
			// sorted keys are the common case
			if (a > b) begin a ^= b; b ^= a; a ^= b; end
			if (b > e) begin b ^= e; e ^= b; b ^= e; end
			if (a > b) begin a ^= b; b ^= a; a ^= b; end
		end
		write_curve(c, a, b, e, 2'($urandom()));
	endtask

	task automatic test_random(int beats);
		int c;
		logic signed [15:0] lk;
		for (int c2 = 0; c2 < CURVES; c2++)
			random_curve(c2);
		for (int n = 0; n < beats; n++) begin
			idle_on = !(n >= beats / 3 && n < beats / 3 + 150);
			c = $urandom_range(CURVES - 1);
			if ($urandom_range(9) == 0) begin
				send_beat(hkc_pkg::ACT_WRITE, 4'(c), 2'($urandom()), {$urandom(), $urandom()},
					16'($urandom()));
			end else begin
				case ($urandom_range(3))
					0: lk = key_x(c, $urandom_range(2));
					1: lk = key_x(c, $urandom_range(2)) + 16'($signed(5'($urandom())));
					default: lk = 16'($urandom());
				endcase
				send_beat(hkc_pkg::ACT_EVAL, 4'(c), 2'($urandom()), {$urandom(), $urandom()},
					lk);
			end
		end
		idle_on = 1'b1;
		drain();
	endtask

	task automatic test_backpressure();
		hold_count = 300;
		hold_sink = 1'b1;
		for (int n = 0; n < 60; n++)
			send_beat(hkc_pkg::ACT_EVAL, 4'($urandom_range(CURVES - 1)), 2'd0, 64'd0,
				16'($urandom()));
		drain();
	endtask

	// result side: stall at random or during a hold-off, check each beat
	always @(posedge clk) begin
		if (hold_sink) begin
			curve_stall <= 1'b1;
			if (hold_count == 0)
				hold_sink <= 1'b0;
			else
				hold_count <= hold_count - 1;
		end else begin
			curve_stall <= idle_on && ($urandom_range(99) < 28);
		end
		if (arst_n && curve_valid && !curve_stall) begin
			if (pending_values.size() == 0) begin
				$display("%0t: unexpected curve beat, actual %0d", $time, curve_value);
				errors++;
			end else begin
				if (curve_value !== pending_values[0]) begin
					$display("%0t: curve_value expected %0d actual %0d", $time,
						pending_values[0], curve_value);
					errors++;
				end
				void'(pending_values.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** three_key_hermite_curve_eval: FAILED **");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		idle_on = 1'b1;
		hold_sink = 1'b0;
		hold_count = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		action = hkc_pkg::ACT_EVAL;
		curve_index = '0;
		key_select = '0;
		key_word = '0;
		lookup = '0;
		curve_stall = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1200);
		test_backpressure();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && pending_values.size() == 0)
			$display("** three_key_hermite_curve_eval: PASSED **");
		else
			$display("** three_key_hermite_curve_eval: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
